>>> src/round_robin_thread_scheduler_defines.svh
// Assertion macros for the round-robin thread scheduler.
// IMPL checks the consequent in the same cycle, NEXT in the cycle after.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define RRTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rrts assertion failed");
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrts assertion failed");
`else
`define RRTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/rrts_pkg.sv
package rrts_pkg;

	// sizes
	localparam int MAX_THREADS    = 16;
	localparam int TID_W          = $clog2(MAX_THREADS);
	localparam int CNT_W          = TID_W + 1;
	localparam int NUM_PRIORITIES = 4;
	localparam int PRIO_W         = 2;
	localparam int QUANTUM_WIDTH  = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int MASK_W         = 4;
	localparam int VAL_W          = 32;

	// fixed values
	localparam logic [TID_W-1:0]         ROOT_TID               = '0;
	localparam logic [VAL_W-1:0]         BOOT_QUANTA            = 32'd1;
	localparam logic [CNT_W-1:0]         BOOT_LIVE              = 5'd1;
	localparam logic [CFG_W-1:0]         QUANTUM_RESET          = 16'd100;
	localparam logic [MASK_W-1:0]        MASK_RESET             = 4'd1;

	// operation codes
	localparam logic [2:0] FUNC_TICK      = 3'd0;
	localparam logic [2:0] FUNC_SPAWN     = 3'd1;
	localparam logic [2:0] FUNC_BLOCK     = 3'd2;
	localparam logic [2:0] FUNC_RESUME    = 3'd3;
	localparam logic [2:0] FUNC_TERMINATE = 3'd4;
	localparam logic [2:0] FUNC_SET_PRIO  = 3'd5;
	localparam logic [2:0] FUNC_QUERY     = 3'd6;
	localparam logic [2:0] FUNC_UNUSED    = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_HALT = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_P0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_P1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_P2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_P3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MASK  = 3'd4;

	typedef struct packed {
		logic [2:0]        func;
		logic [TID_W-1:0]  thread_id;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [VAL_W-1:0]  value;
		logic [TID_W-1:0]  running_id;
		logic [VAL_W-1:0]  total_quantums;
		logic              switched;
	} rsp_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

>>> src/rrts_cfg.sv
module rrts_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rrts_pkg::cfg_wr_t                    wr,
	input  logic [rrts_pkg::PRIO_W-1:0]          qprio,
	input  logic [rrts_pkg::PRIO_W-1:0]          uprio,
	output logic [rrts_pkg::QUANTUM_WIDTH-1:0]   quantum,
	output logic                                 usable
);

	logic [rrts_pkg::CFG_W-1:0]  quantum_q [rrts_pkg::NUM_PRIORITIES];
	logic [rrts_pkg::MASK_W-1:0] mask_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < rrts_pkg::NUM_PRIORITIES; p++) begin
				quantum_q[p] <= rrts_pkg::QUANTUM_RESET;
			end
			mask_q <= rrts_pkg::MASK_RESET;
		end else if (wr.valid) begin
			unique case (wr.index)
				rrts_pkg::CFG_QUANTUM_P0: quantum_q[0] <= wr.data;
				rrts_pkg::CFG_QUANTUM_P1: quantum_q[1] <= wr.data;
				rrts_pkg::CFG_QUANTUM_P2: quantum_q[2] <= wr.data;
				rrts_pkg::CFG_QUANTUM_P3: quantum_q[3] <= wr.data;
				rrts_pkg::CFG_PRIO_MASK:  mask_q <= wr.data[rrts_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// quantum lookup and priority check
	assign quantum = quantum_q[qprio][rrts_pkg::QUANTUM_WIDTH-1:0];
	assign usable  = mask_q[uprio];

endmodule

>>> src/round_robin_thread_scheduler.sv
// Round-robin thread scheduler: one request (tick, spawn, block, resume,
// terminate, set priority, query) in, one response out. Requests are handled
// one at a time by a sequencer around two memories with registered reads
// (ready queue ids and per-thread quanta counts). A plain request passes
// through accept, execute and response, a query adds a quanta read; a thread
// switch adds the queue pop and the quanta read-modify-write, and the hand-over
// waits for a pending queue write when it follows a queue walk; block of a
// waiting thread and terminate walk the ready queue entry by entry, reading and
// checking each one. Configuration writes are always accepted (cfg_ready is
// tied high) and must only be made while the block is idle.
module round_robin_thread_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  rrts_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output rrts_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rrts_pkg::CFG_W-1:0]        cfg_data
);

	`include "round_robin_thread_scheduler_defines.svh"

	localparam int TW = rrts_pkg::TID_W;
	localparam int CW = rrts_pkg::CNT_W;
	localparam int VW = rrts_pkg::VAL_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_SW_RD = 4'd3;
	localparam logic [3:0] S_SW_WR = 4'd4;
	localparam logic [3:0] S_WRD   = 4'd5;
	localparam logic [3:0] S_WCHK  = 4'd6;
	localparam logic [3:0] S_HAND  = 4'd7;
	localparam logic [3:0] S_QUERY = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0]                         state_q;
	logic [2:0]                         func_q;
	logic [TW-1:0]                      tid_q;
	logic [rrts_pkg::PRIO_W-1:0]        prio_q;
	logic [rrts_pkg::MAX_THREADS-1:0]   valid_q;
	logic [rrts_pkg::MAX_THREADS-1:0]   blocked_q;
	logic [rrts_pkg::PRIO_W-1:0]        prio_tab_q [rrts_pkg::MAX_THREADS];
	logic [TW-1:0]                      head_q;
	logic [CW-1:0]                      count_q;
	logic [TW-1:0]                      cur_q;
	logic [rrts_pkg::QUANTUM_WIDTH-1:0] ticks_q;
	logic [VW-1:0]                      total_q;
	logic [CW-1:0]                      live_q;
	logic                               stopped_q;
	logic [TW-1:0]                      next_q;
	logic                               push_cur_q;
	logic                               hand_after_q;
	logic [CW-1:0]                      walk_i_q;
	logic [CW-1:0]                      walk_n_q;
	logic [1:0]                         status_q;
	logic [VW-1:0]                      value_q;
	logic                               switched_q;

	// memory write requests, registered and applied in the cycle after they are issued
	logic                               ready_we_q;
	logic [TW-1:0]                      ready_waddr_q;
	logic [TW-1:0]                      ready_wdata_q;
	logic                               quanta_we_q;
	logic [TW-1:0]                      quanta_waddr_q;
	logic [VW-1:0]                      quanta_wdata_q;
	logic [rrts_pkg::MAX_THREADS-1:0]   quanta_written_q;
	logic                               quanta_hit_q;
	logic                               quanta_zero_q;

	logic [TW-1:0] ready_mem [rrts_pkg::MAX_THREADS];
	logic [VW-1:0] quanta_mem [rrts_pkg::MAX_THREADS];
	logic [TW-1:0] ready_rd_q;
	logic [VW-1:0] quanta_raw_q;

	logic [TW-1:0]                      ready_raddr;
	logic [TW-1:0]                      quanta_raddr;
	logic [VW-1:0]                      quanta_rd;
	logic [TW-1:0]                      prio_raddr;
	logic [rrts_pkg::QUANTUM_WIDTH-1:0] quantum;
	logic                               usable;
	logic [TW-1:0]                      free_id;
	logic                               free_found;
	logic [TW-1:0]                      tail;
	logic                               keep;
	rrts_pkg::cfg_wr_t                  cfg_wr;

	// configuration registers
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	rrts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cfg_wr),
		.qprio   (prio_tab_q[prio_raddr]),
		.uprio   (prio_q),
		.quantum (quantum),
		.usable  (usable)
	);

	// read addresses of the memories and the priority table
	assign ready_raddr  = (state_q == S_WRD) ? head_q + walk_i_q[TW-1:0] : head_q;
	assign quanta_raddr = (state_q == S_SW_RD) ? next_q : tid_q;
	assign prio_raddr   = (state_q == S_SW_RD) ? next_q : cur_q;
	assign tail         = head_q + count_q[TW-1:0];
	assign keep         = ready_rd_q != tid_q;

	// unwritten quanta entries read as their reset value
	assign quanta_rd = quanta_hit_q ? quanta_raw_q :
		(quanta_zero_q ? rrts_pkg::BOOT_QUANTA : '0);

	// lowest free slot
	always_comb begin
		free_id = '0;
		for (int i = rrts_pkg::MAX_THREADS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_id = TW'(i);
			end
		end
	end
	assign free_found = ~&valid_q;

	// memories
	always_ff @(posedge clk) begin
		if (ready_we_q) begin
			ready_mem[ready_waddr_q] <= ready_wdata_q;
		end
		ready_rd_q <= ready_mem[ready_raddr];
	end

	always_ff @(posedge clk) begin
		if (quanta_we_q) begin
			quanta_mem[quanta_waddr_q] <= quanta_wdata_q;
		end
		quanta_raw_q <= quanta_mem[quanta_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			func_q           <= rrts_pkg::FUNC_TICK;
			tid_q            <= '0;
			prio_q           <= '0;
			valid_q          <= '0;
			valid_q[rrts_pkg::ROOT_TID] <= 1'b1;
			blocked_q        <= '0;
			for (int i = 0; i < rrts_pkg::MAX_THREADS; i++) begin
				prio_tab_q[i] <= '0;
			end
			head_q           <= '0;
			count_q          <= '0;
			cur_q            <= rrts_pkg::ROOT_TID;
			ticks_q          <= rrts_pkg::QUANTUM_RESET[rrts_pkg::QUANTUM_WIDTH-1:0];
			total_q          <= rrts_pkg::BOOT_QUANTA;
			live_q           <= rrts_pkg::BOOT_LIVE;
			stopped_q        <= 1'b0;
			next_q           <= '0;
			push_cur_q       <= 1'b0;
			hand_after_q     <= 1'b0;
			walk_i_q         <= '0;
			walk_n_q         <= '0;
			status_q         <= rrts_pkg::ST_OK;
			value_q          <= '0;
			switched_q       <= 1'b0;
			ready_we_q       <= 1'b0;
			ready_waddr_q    <= '0;
			ready_wdata_q    <= '0;
			quanta_we_q      <= 1'b0;
			quanta_waddr_q   <= '0;
			quanta_wdata_q   <= '0;
			quanta_written_q <= '0;
			quanta_hit_q     <= 1'b0;
			quanta_zero_q    <= 1'b0;
		end else begin
			ready_we_q    <= 1'b0;
			quanta_we_q   <= 1'b0;
			quanta_hit_q  <= quanta_written_q[quanta_raddr];
			quanta_zero_q <= quanta_raddr == rrts_pkg::ROOT_TID;
			if (quanta_we_q) begin
				quanta_written_q[quanta_waddr_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q  <= req.func;
						tid_q   <= req.thread_id;
						prio_q  <= req.priority_req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q   <= rrts_pkg::ST_FAIL;
					value_q    <= '0;
					switched_q <= 1'b0;
					state_q    <= S_OUT;
					if (stopped_q) begin
						status_q <= rrts_pkg::ST_HALT;
					end else begin
						unique case (func_q)
							rrts_pkg::FUNC_TICK: begin
								status_q <= rrts_pkg::ST_OK;
								if (ticks_q > 1) begin
									ticks_q <= ticks_q - 1'b1;
								end else if (count_q == '0) begin
									ticks_q <= quantum;
								end else begin
									push_cur_q <= 1'b1;
									state_q    <= S_POP;
								end
							end
							rrts_pkg::FUNC_SPAWN: begin
								if (live_q < CW'(rrts_pkg::MAX_THREADS) && usable
									&& free_found) begin
									valid_q[free_id]    <= 1'b1;
									blocked_q[free_id]  <= 1'b0;
									prio_tab_q[free_id] <= prio_q;
									quanta_we_q         <= 1'b1;
									quanta_waddr_q      <= free_id;
									quanta_wdata_q      <= '0;
									live_q              <= live_q + 1'b1;
									ready_we_q          <= 1'b1;
									ready_waddr_q       <= tail;
									ready_wdata_q       <= free_id;
									count_q             <= count_q + 1'b1;
									status_q            <= rrts_pkg::ST_OK;
									value_q             <= VW'(free_id);
								end
							end
							rrts_pkg::FUNC_BLOCK: begin
								if (valid_q[tid_q] && tid_q != rrts_pkg::ROOT_TID) begin
									status_q <= rrts_pkg::ST_OK;
									if (!blocked_q[tid_q]) begin
										blocked_q[tid_q] <= 1'b1;
										walk_i_q         <= '0;
										walk_n_q         <= '0;
										hand_after_q     <= 1'b0;
										if (tid_q == cur_q) begin
											state_q <= S_HAND;
										end else if (count_q != '0) begin
											state_q <= S_WRD;
										end
									end
								end
							end
							rrts_pkg::FUNC_RESUME: begin
								if (valid_q[tid_q]) begin
									status_q <= rrts_pkg::ST_OK;
									if (blocked_q[tid_q]) begin
										blocked_q[tid_q] <= 1'b0;
										ready_we_q       <= 1'b1;
										ready_waddr_q    <= tail;
										ready_wdata_q    <= tid_q;
										count_q          <= count_q + 1'b1;
									end
								end
							end
							rrts_pkg::FUNC_TERMINATE: begin
								if (valid_q[tid_q]) begin
									if (tid_q == rrts_pkg::ROOT_TID) begin
										stopped_q <= 1'b1;
										status_q  <= rrts_pkg::ST_HALT;
									end else begin
										status_q          <= rrts_pkg::ST_OK;
										valid_q[tid_q]    <= 1'b0;
										blocked_q[tid_q]  <= 1'b0;
										prio_tab_q[tid_q] <= '0;
										quanta_we_q       <= 1'b1;
										quanta_waddr_q    <= tid_q;
										quanta_wdata_q    <= '0;
										live_q            <= live_q - 1'b1;
										walk_i_q          <= '0;
										walk_n_q          <= '0;
										hand_after_q      <= tid_q == cur_q;
										if (count_q != '0) begin
											state_q <= S_WRD;
										end else if (tid_q == cur_q) begin
											state_q <= S_HAND;
										end
									end
								end
							end
							rrts_pkg::FUNC_SET_PRIO: begin
								if (valid_q[tid_q] && usable) begin
									prio_tab_q[tid_q] <= prio_q;
									status_q          <= rrts_pkg::ST_OK;
								end
							end
							rrts_pkg::FUNC_QUERY: begin
								if (valid_q[tid_q]) begin
									status_q <= rrts_pkg::ST_OK;
									state_q  <= S_QUERY;
								end
							end
							default: ;
						endcase
					end
				end
				// running thread leaves: pop the head, or fall back to thread 0;
				// a pending queue write from the walk lands before the head is read
				S_HAND: begin
					if (count_q == '0) begin
						next_q  <= rrts_pkg::ROOT_TID;
						state_q <= S_SW_RD;
					end else if (!ready_we_q) begin
						state_q <= S_POP;
					end
				end
				// head id arrives; on quantum expiry the running thread goes to the back
				S_POP: begin
					next_q     <= ready_rd_q;
					head_q     <= head_q + 1'b1;
					push_cur_q <= 1'b0;
					if (push_cur_q) begin
						ready_we_q    <= 1'b1;
						ready_waddr_q <= tail;
						ready_wdata_q <= cur_q;
					end else begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_SW_RD;
				end
				// switch: new thread runs, quanta read issued
				S_SW_RD: begin
					cur_q      <= next_q;
					total_q    <= total_q + 1'b1;
					switched_q <= 1'b1;
					ticks_q    <= quantum;
					state_q    <= S_SW_WR;
				end
				S_SW_WR: begin
					quanta_we_q    <= 1'b1;
					quanta_waddr_q <= cur_q;
					quanta_wdata_q <= quanta_rd + 1'b1;
					state_q        <= S_OUT;
				end
				// queue compaction: read entry i
				S_WRD: begin
					state_q <= S_WCHK;
				end
				// keep entries other than the target, packed toward the head
				S_WCHK: begin
					if (keep) begin
						ready_we_q    <= 1'b1;
						ready_waddr_q <= head_q + walk_n_q[TW-1:0];
						ready_wdata_q <= ready_rd_q;
						walk_n_q      <= walk_n_q + 1'b1;
					end
					walk_i_q <= walk_i_q + 1'b1;
					if (walk_i_q + 1'b1 == count_q) begin
						count_q <= walk_n_q + CW'(keep);
						state_q <= hand_after_q ? S_HAND : S_OUT;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_QUERY: begin
					value_q <= quanta_rd;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// handshake and response
	assign req_stall          = state_q != S_IDLE;
	assign rsp_valid          = state_q == S_OUT;
	assign rsp.status         = status_q;
	assign rsp.value          = value_q;
	assign rsp.running_id     = cur_q;
	assign rsp.total_quantums = total_q;
	assign rsp.switched       = switched_q;

	// checks
	`RRTS_ASSERT_NEXT(a_halt_sticky, clk, arst_n, stopped_q, stopped_q)
	`RRTS_ASSERT_IMPL(a_main_alive, clk, arst_n, 1'b1, valid_q[0] && !blocked_q[0])
	`RRTS_ASSERT_IMPL(a_queue_fits, clk, arst_n, state_q == S_IDLE, count_q < live_q)
	`RRTS_ASSERT_NEXT(a_accept_exec, clk, arst_n, req_valid && !req_stall, state_q == S_EXEC)

endmodule

>>> sim/tb_round_robin_thread_scheduler.sv
module tb_round_robin_thread_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int TW             = rrts_pkg::TID_W;
	localparam int VW             = rrts_pkg::VAL_W;
	localparam int PW             = rrts_pkg::PRIO_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	rrts_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rrts_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rrts_pkg::CFG_W-1:0] cfg_data = '0;

	round_robin_thread_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// scheduler shadow state
	logic                thr_valid [rrts_pkg::MAX_THREADS];
	logic                thr_blocked [rrts_pkg::MAX_THREADS];
	logic [PW-1:0]       thr_prio [rrts_pkg::MAX_THREADS];
	logic [VW-1:0]       thr_quanta [rrts_pkg::MAX_THREADS];
	logic [TW-1:0]       ready_list [$];
	logic [TW-1:0]       running;
	logic [rrts_pkg::QUANTUM_WIDTH-1:0] ticks_left;
	logic [VW-1:0]       switch_count;
	int                  live_threads;
	logic                halted;
	logic [rrts_pkg::CFG_W-1:0]  quantum_len [rrts_pkg::NUM_PRIORITIES];
	logic [rrts_pkg::MASK_W-1:0] prio_mask;

	rrts_pkg::req_t pending_req [$];
	rrts_pkg::rsp_t expected_rsp [$];
	int   errors = 0;
	int   n_req = 0, n_rsp = 0, n_switch = 0, n_halt = 0;
	bit   calm = 1'b0;
	int   quiet_cycles = 0;

	function automatic bit prio_ok(logic [PW-1:0] p);
		return prio_mask[p];
	endfunction

	function automatic void ready_drop(logic [TW-1:0] id);
		for (int i = ready_list.size() - 1; i >= 0; i--)
			if (ready_list[i] == id)
				ready_list.delete(i);
	endfunction

	function automatic void ready_add(logic [TW-1:0] id);
		if (ready_list.size() < rrts_pkg::MAX_THREADS)
			ready_list.insert(ready_list.size(), id);
	endfunction

	function automatic logic [TW-1:0] ready_take();
		logic [TW-1:0] id;
		id = ready_list[0];
		ready_list.delete(0);
		return id;
	endfunction

	function automatic void run_thread(logic [TW-1:0] id);
		running = id;
		switch_count++;
		thr_quanta[id]++;
		ticks_left = quantum_len[thr_prio[id]];
	endfunction

	// running thread leaves: queue head or main thread takes over
	function automatic void hand_over();
		logic [TW-1:0] nxt;
		nxt = rrts_pkg::ROOT_TID;
		if (ready_list.size() != 0)
			nxt = ready_take();
		run_thread(nxt);
	endfunction

	function automatic void reset_schedule();
		for (int i = 0; i < rrts_pkg::MAX_THREADS; i++) begin
			thr_valid[i] = 1'b0;
			thr_blocked[i] = 1'b0;
			thr_prio[i] = '0;
			thr_quanta[i] = '0;
		end
		for (int p = 0; p < rrts_pkg::NUM_PRIORITIES; p++)
			quantum_len[p] = rrts_pkg::QUANTUM_RESET;
		prio_mask = rrts_pkg::MASK_RESET;
		thr_valid[rrts_pkg::ROOT_TID] = 1'b1;
		thr_quanta[rrts_pkg::ROOT_TID] = rrts_pkg::BOOT_QUANTA;
		ready_list.delete();
		running = rrts_pkg::ROOT_TID;
		ticks_left = rrts_pkg::QUANTUM_RESET;
		switch_count = rrts_pkg::BOOT_QUANTA;
		live_threads = int'(rrts_pkg::BOOT_LIVE);
		halted = 1'b0;
	endfunction

	// compute the response of one request and advance the shadow state
	function automatic rrts_pkg::rsp_t schedule_request(rrts_pkg::req_t r);
		rrts_pkg::rsp_t o;
		logic [VW-1:0] prev_total;
		logic [TW-1:0] prev_run;
		logic [TW-1:0] t;
		logic [TW-1:0] nxt;
		bit exists;
		bit found;
		prev_total = switch_count;
		prev_run = running;
		t = r.thread_id;
		exists = thr_valid[t];
		o = '0;
		o.status = rrts_pkg::ST_FAIL;
		if (halted) begin
			o.status = rrts_pkg::ST_HALT;
		end else begin
			case (r.func)
				rrts_pkg::FUNC_TICK: begin
					o.status = rrts_pkg::ST_OK;
					if (ticks_left > 1) begin
						ticks_left--;
					end else if (ready_list.size() == 0) begin
						ticks_left = quantum_len[thr_prio[running]];
					end else begin
						nxt = ready_take();
						ready_add(running);
						run_thread(nxt);
					end
				end
				rrts_pkg::FUNC_SPAWN: begin
					if (live_threads < rrts_pkg::MAX_THREADS && prio_ok(r.priority_req)) begin
						found = 1'b0;
						nxt = '0;
						for (int i = 0; i < rrts_pkg::MAX_THREADS; i++)
							if (!found && !thr_valid[i]) begin
								nxt = TW'(i);
								found = 1'b1;
							end
						if (found) begin
							ready_drop(nxt);
							thr_valid[nxt] = 1'b1;
							thr_blocked[nxt] = 1'b0;
							thr_prio[nxt] = r.priority_req;
							thr_quanta[nxt] = '0;
							live_threads++;
							ready_add(nxt);
							o.status = rrts_pkg::ST_OK;
							o.value = VW'(nxt);
						end
					end
				end
				rrts_pkg::FUNC_BLOCK: begin
					if (exists && t != rrts_pkg::ROOT_TID) begin
						o.status = rrts_pkg::ST_OK;
						if (!thr_blocked[t]) begin
							thr_blocked[t] = 1'b1;
							if (t == running)
								hand_over();
							else
								ready_drop(t);
						end
					end
				end
				rrts_pkg::FUNC_RESUME: begin
					if (exists) begin
						o.status = rrts_pkg::ST_OK;
						if (thr_blocked[t]) begin
							thr_blocked[t] = 1'b0;
							ready_add(t);
						end
					end
				end
				rrts_pkg::FUNC_TERMINATE: begin
					if (exists) begin
						if (t == rrts_pkg::ROOT_TID) begin
							halted = 1'b1;
							o.status = rrts_pkg::ST_HALT;
						end else begin
							o.status = rrts_pkg::ST_OK;
							thr_valid[t] = 1'b0;
							thr_blocked[t] = 1'b0;
							thr_prio[t] = '0;
							thr_quanta[t] = '0;
							live_threads--;
							ready_drop(t);
							if (t == running)
								hand_over();
						end
					end
				end
				rrts_pkg::FUNC_SET_PRIO: begin
					if (exists && prio_ok(r.priority_req)) begin
						thr_prio[t] = r.priority_req;
						o.status = rrts_pkg::ST_OK;
					end
				end
				rrts_pkg::FUNC_QUERY: begin
					if (exists) begin
						o.status = rrts_pkg::ST_OK;
						o.value = thr_quanta[t];
					end
				end
				default: ;
			endcase
		end
		o.running_id = running;
		o.total_quantums = switch_count;
		o.switched = (switch_count != prev_total) || (running != prev_run);
		return o;
	endfunction

	task automatic report(string field, logic [VW-1:0] got, logic [VW-1:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsp.insert(expected_rsp.size(), schedule_request(req));
				n_req++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_req.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
					req <= pending_req[0];
					pending_req.delete(0);
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		rrts_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (expected_rsp.size() == 0) begin
					report("unexpected response", VW'(1), VW'(0));
				end else begin
					want = expected_rsp[0];
					expected_rsp.delete(0);
					if (rsp.status !== want.status)
						report("status", VW'(rsp.status), VW'(want.status));
					if (rsp.value !== want.value)
						report("value", rsp.value, want.value);
					if (rsp.running_id !== want.running_id)
						report("running_id", VW'(rsp.running_id), VW'(want.running_id));
					if (rsp.total_quantums !== want.total_quantums)
						report("total_quantums", rsp.total_quantums, want.total_quantums);
					if (rsp.switched !== want.switched)
						report("switched", VW'(rsp.switched), VW'(want.switched));
					if (want.switched)
						n_switch++;
					if (want.status == rrts_pkg::ST_HALT)
						n_halt++;
				end
			end
			rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(logic [rrts_pkg::CFG_IDX_W-1:0] idx,
		logic [rrts_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rrts_pkg::CFG_PRIO_MASK)
			prio_mask = val[rrts_pkg::MASK_W-1:0];
		else
			quantum_len[idx[1:0]] = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic add(logic [2:0] f, logic [TW-1:0] id, logic [PW-1:0] p);
		rrts_pkg::req_t r;
		r.func = f;
		r.thread_id = id;
		r.priority_req = p;
		pending_req.insert(pending_req.size(), r);
	endtask

	// mostly well-formed requests, biased toward live low ids
	task automatic add_random(int n);
		int pick;
		logic [2:0] f;
		logic [TW-1:0] id;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) f = rrts_pkg::FUNC_TICK;
			else if (pick < 50) f = rrts_pkg::FUNC_SPAWN;
			else if (pick < 62) f = rrts_pkg::FUNC_BLOCK;
			else if (pick < 74) f = rrts_pkg::FUNC_RESUME;
			else if (pick < 84) f = rrts_pkg::FUNC_TERMINATE;
			else if (pick < 92) f = rrts_pkg::FUNC_SET_PRIO;
			else if (pick < 98) f = rrts_pkg::FUNC_QUERY;
			else f = rrts_pkg::FUNC_UNUSED;
			id = ($urandom_range(0, 1) != 0) ? TW'($urandom_range(0, 7))
				: TW'($urandom_range(0, 15));
			// keep the main thread alive until the last phase
			if (f == rrts_pkg::FUNC_TERMINATE && id == rrts_pkg::ROOT_TID)
				id = TW'($urandom_range(1, 15));
			add(f, id, PW'($urandom_range(0, 3)));
		end
	endtask

	// wait until every response is back, then let the block settle
	task automatic drain();
		do @(posedge clk);
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		reset_schedule();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// default settings: basic operations and failure cases
		add(rrts_pkg::FUNC_QUERY, 0, 0);
		add(rrts_pkg::FUNC_SPAWN, 0, 0);
		add(rrts_pkg::FUNC_SPAWN, 0, 1);
		add(rrts_pkg::FUNC_BLOCK, 0, 0);
		add(rrts_pkg::FUNC_BLOCK, 1, 0);
		add(rrts_pkg::FUNC_BLOCK, 1, 0);
		add(rrts_pkg::FUNC_RESUME, 1, 0);
		add(rrts_pkg::FUNC_RESUME, 1, 0);
		add(rrts_pkg::FUNC_QUERY, 15, 3);
		add(rrts_pkg::FUNC_UNUSED, 15, 3);
		add(rrts_pkg::FUNC_SET_PRIO, 1, 0);
		add(rrts_pkg::FUNC_SET_PRIO, 1, 2);
		add(rrts_pkg::FUNC_TICK, 0, 0);
		add(rrts_pkg::FUNC_TERMINATE, 1, 0);
		add(rrts_pkg::FUNC_TERMINATE, 1, 0);
		add(rrts_pkg::FUNC_RESUME, 9, 0);
		drain();

		// short quanta, all priorities: fill the table, then churn
		write_reg(rrts_pkg::CFG_QUANTUM_P0, 16'd1);
		write_reg(rrts_pkg::CFG_QUANTUM_P1, 16'd2);
		write_reg(rrts_pkg::CFG_QUANTUM_P2, 16'd3);
		write_reg(rrts_pkg::CFG_QUANTUM_P3, 16'd4);
		write_reg(rrts_pkg::CFG_PRIO_MASK, 16'hf);
		for (int i = 0; i < 16; i++)
			add(rrts_pkg::FUNC_SPAWN, 0, i[1:0]);
		add(rrts_pkg::FUNC_TICK, 0, 0);
		add(rrts_pkg::FUNC_TICK, 0, 0);
		add(rrts_pkg::FUNC_BLOCK, 15, 3);
		add(rrts_pkg::FUNC_TERMINATE, 14, 0);
		add_random(500);
		drain();

		// extreme quantum lengths, including zero, and a sparse mask
		write_reg(rrts_pkg::CFG_QUANTUM_P0, 16'hffff);
		write_reg(rrts_pkg::CFG_QUANTUM_P1, 16'd0);
		write_reg(rrts_pkg::CFG_QUANTUM_P3, 16'd1);
		write_reg(rrts_pkg::CFG_PRIO_MASK, 16'b1010);
		calm = 1'b1;
		add_random(300);
		drain();
		calm = 1'b0;
		add_random(200);
		drain();

		// random small quanta, full mask
		for (int p = 0; p < rrts_pkg::NUM_PRIORITIES; p++)
			write_reg(p[rrts_pkg::CFG_IDX_W-1:0], rrts_pkg::CFG_W'($urandom_range(1, 6)));
		write_reg(rrts_pkg::CFG_PRIO_MASK, 16'hf);
		add_random(500);
		drain();

		// terminating the main thread halts everything after it
		add(rrts_pkg::FUNC_TERMINATE, rrts_pkg::ROOT_TID, 0);
		add(rrts_pkg::FUNC_TICK, 0, 0);
		add(rrts_pkg::FUNC_SPAWN, 0, 0);
		add(rrts_pkg::FUNC_QUERY, 0, 0);
		add(rrts_pkg::FUNC_TERMINATE, 0, 0);
		drain();

		$display("%0d requests, %0d responses checked, %0d thread switches, %0d halted replies",
			n_req, n_rsp, n_switch, n_halt);
		$display("covered default, short, extreme and zero quanta and priority masks 1, 10, 15");
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
